// ===== hdl/pgtm_pkg.sv =====
// shared types, constants and helpers for the four-level page table mapper
// no dependencies; every other file imports this package
package pgtm_pkg;

    // table geometry
    localparam int TABLE_COUNT       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_W             = $clog2(TABLE_COUNT);
    localparam int CNT_W             = $clog2(TABLE_COUNT + 1);
    localparam int ADDR_W            = TBL_W + IDX_W;
    localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;

    // field widths
    localparam int FRAME_W  = 40;
    localparam int FLAG_W   = 12;
    localparam int PAGE_W   = 36;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 7;
    localparam int ENTRY_W  = FRAME_W + FLAG_W;
    localparam int LEVEL_W  = 2;

    localparam logic [FRAME_W-1:0] TAF_RESET  = FRAME_W'(256);
    localparam logic [LEVEL_W-1:0] LEVEL_LAST_LINK = LEVEL_W'(2);
    localparam logic [IDX_W-1:0]   IDX_LAST   = '1;

    typedef enum logic {
        CMD_MAP   = 1'b0,
        CMD_UNMAP = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_CLEAR,
        S_LINK,
        S_LEAF,
        S_DONE
    } t_state;

    typedef enum logic {
        FU_ADD = 1'b0,
        FU_SUB = 1'b1
    } t_fu_op;

    // request to the shared frame adder
    typedef struct packed {
        t_fu_op             op;
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
    } t_fu_req;

    // result of the shared frame adder
    typedef struct packed {
        logic [FRAME_W-1:0] sum;
        logic               in_area;
    } t_fu_rsp;

    // one write port and one read port on the table store
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_store_req;

    // 9-bit index of one level, top level first
    function automatic logic [IDX_W-1:0] level_index(input logic [PAGE_W-1:0] page,
                                                     input logic [LEVEL_W-1:0] level);
        logic [IDX_W-1:0] idx;
        case (level)
            2'd0:    idx = page[4*IDX_W-1:3*IDX_W];
            2'd1:    idx = page[3*IDX_W-1:2*IDX_W];
            2'd2:    idx = page[2*IDX_W-1:IDX_W];
            default: idx = page[IDX_W-1:0];
        endcase
        return idx;
    endfunction

endpackage

// ===== hdl/pgtm_in_if.sv =====
// input channel of the page table mapper: valid/ready with one command item
// depends on pgtm_pkg
interface pgtm_in_if import pgtm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [PAGE_W-1:0]  virt_page;
    logic [FRAME_W-1:0] phys_frame;
    logic [FLAG_W-1:0]  page_flags;

    modport source (output valid, command, virt_page, phys_frame, page_flags, input ready);
    modport sink   (input valid, command, virt_page, phys_frame, page_flags, output ready);
endinterface

// ===== hdl/pgtm_out_if.sv =====
// result channel of the page table mapper: valid/ready with one result item
// depends on pgtm_pkg
interface pgtm_out_if import pgtm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                invalidate;
    logic [PAGE_W-1:0]   invalidate_page;
    logic [USED_W-1:0]   tables_used;

    modport source (output valid, status, invalidate, invalidate_page, tables_used,
                    input ready);
    modport sink   (input valid, status, invalidate, invalidate_page, tables_used,
                    output ready);
endinterface

// ===== hdl/pgtm_frame_unit.sv =====
// shared 40-bit frame adder: links a new table or locates a followed one
// depends on pgtm_pkg
module pgtm_frame_unit import pgtm_pkg::*; (
    input  t_fu_req i_req,
    output t_fu_rsp o_rsp
);
    logic [FRAME_W-1:0] w_b;
    logic               w_cin;

    // subtract as add of the inverted operand plus one
    assign w_b   = (i_req.op == FU_SUB) ? ~i_req.b : i_req.b;
    assign w_cin = (i_req.op == FU_SUB);

    assign o_rsp.sum     = i_req.a + w_b + FRAME_W'(w_cin);
    assign o_rsp.in_area = (o_rsp.sum < FRAME_W'(TABLE_COUNT));
endmodule

// ===== hdl/pgtm_table_store.sv =====
// table store: all page tables in one memory, one write and one registered read a cycle
// depends on pgtm_pkg
module pgtm_table_store import pgtm_pkg::*; (
    input  logic               i_clk,
    input  t_store_req         i_req,
    output logic [ENTRY_W-1:0] o_rdata
);
    logic [ENTRY_W-1:0] r_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/pgtm_walk_ctrl.sv =====
// walk sequencer: steps through the levels, allocates and clears tables, holds the result
// depends on pgtm_pkg, pgtm_in_if, pgtm_out_if
module pgtm_walk_ctrl import pgtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [FRAME_W-1:0] i_table_area_frame,
    input  logic [ENTRY_W-1:0] i_rdata,
    input  t_fu_rsp            i_fu_rsp,
    output t_fu_req            o_fu_req,
    output t_store_req         o_store_req,
    pgtm_in_if.sink            i_in,
    pgtm_out_if.source         o_out
);
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [FLAG_W-1:0]  r_flags, n_flags;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [TBL_W-1:0]   r_table, n_table;
    logic [TBL_W-1:0]   r_new_tbl, n_new_tbl;
    logic [IDX_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic [CNT_W-1:0]   r_next_free, n_next_free;
    t_status            r_status, n_status;

    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic                r_out_inv, n_out_inv;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;
    logic [USED_W-1:0]   r_out_used, n_out_used;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_present;
    logic             w_full;
    logic             w_clr_last;
    logic [IDX_W-1:0] w_idx;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_present  = i_rdata[0];
    assign w_full     = (r_next_free >= CNT_W'(TABLE_COUNT));
    assign w_clr_last = (r_clr_cnt == IDX_LAST);
    assign w_idx      = level_index(r_page, r_level);

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.invalidate      = r_out_inv;
    assign o_out.invalidate_page = r_out_page;
    assign o_out.tables_used     = r_out_used;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_present) begin
                    if (!i_fu_rsp.in_area) begin
                        n_state = S_DONE;
                    end else if (r_level == LEVEL_LAST_LINK) begin
                        n_state = S_LEAF;
                    end else begin
                        n_state = S_RD;
                    end
                end else if (r_cmd == CMD_UNMAP || w_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                n_state = (r_level == LEVEL_LAST_LINK) ? S_LEAF : S_RD;
            end
            S_LEAF: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // datapath, store and adder control
    always_comb begin
        n_cmd        = r_cmd;
        n_page       = r_page;
        n_frame      = r_frame;
        n_flags      = r_flags;
        n_level      = r_level;
        n_table      = r_table;
        n_new_tbl    = r_new_tbl;
        n_clr_cnt    = r_clr_cnt;
        n_next_free  = r_next_free;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_inv    = r_out_inv;
        n_out_page   = r_out_page;
        n_out_used   = r_out_used;

        o_store_req.we    = 1'b0;
        o_store_req.waddr = {r_table, w_idx};
        o_store_req.wdata = '0;
        o_store_req.raddr = {r_table, w_idx};

        o_fu_req.op = FU_ADD;
        o_fu_req.a  = i_table_area_frame;
        o_fu_req.b  = FRAME_W'(r_new_tbl);

        case (r_state)
            // clear the root table after reset
            S_INIT: begin
                o_store_req.we    = 1'b1;
                o_store_req.waddr = {TBL_W'(0), r_clr_cnt};
                n_clr_cnt         = r_clr_cnt + 1'b1;
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd    = t_cmd'(i_in.command);
                    n_page   = i_in.virt_page;
                    n_frame  = i_in.phys_frame;
                    n_flags  = i_in.page_flags;
                    n_level  = '0;
                    n_table  = '0;
                    n_status = ST_DONE;
                end
            end
            // locate the linked table relative to the table area
            S_EVAL: begin
                o_fu_req.op = FU_SUB;
                o_fu_req.a  = i_rdata[ENTRY_W-1:FLAG_W];
                o_fu_req.b  = i_table_area_frame;
                if (w_present) begin
                    if (i_fu_rsp.in_area) begin
                        n_table = i_fu_rsp.sum[TBL_W-1:0];
                        n_level = r_level + 1'b1;
                    end else begin
                        n_status = (r_cmd == CMD_MAP) ? ST_NOSPACE : ST_ABSENT;
                    end
                end else if (r_cmd == CMD_UNMAP) begin
                    n_status = ST_ABSENT;
                end else if (w_full) begin
                    n_status = ST_NOSPACE;
                end else begin
                    n_new_tbl   = r_next_free[TBL_W-1:0];
                    n_next_free = r_next_free + 1'b1;
                    n_clr_cnt   = '0;
                end
            end
            // sweep the new table to zero
            S_CLEAR: begin
                o_store_req.we    = 1'b1;
                o_store_req.waddr = {r_new_tbl, r_clr_cnt};
                n_clr_cnt         = r_clr_cnt + 1'b1;
            end
            // link the new table into its parent
            S_LINK: begin
                o_store_req.we    = 1'b1;
                o_store_req.wdata = {i_fu_rsp.sum, r_flags};
                n_table           = r_new_tbl;
                n_level           = r_level + 1'b1;
            end
            // write or clear the leaf
            S_LEAF: begin
                o_store_req.we    = 1'b1;
                o_store_req.wdata = (r_cmd == CMD_MAP) ? {r_frame, r_flags} : '0;
            end
            // hand the result to the output register
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_inv    = (r_cmd == CMD_UNMAP) && (r_status == ST_DONE);
                    n_out_page   = ((r_cmd == CMD_UNMAP) && (r_status == ST_DONE))
                                   ? r_page : '0;
                    n_out_used   = USED_W'(r_next_free);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_cnt   <= '0;
            r_next_free <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_page       <= n_page;
        r_frame      <= n_frame;
        r_flags      <= n_flags;
        r_level      <= n_level;
        r_table      <= n_table;
        r_new_tbl    <= n_new_tbl;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_inv    <= n_out_inv;
        r_out_page   <= n_out_page;
        r_out_used   <= n_out_used;
    end

    // an accepted item starts with a read of the root level
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_RD) && (r_level == '0) && (r_table == '0))
        else $error("walk did not start at the root");

    // every allocation starts a clearing sweep at entry zero
    a_alloc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_next_free != $past(r_next_free)))
        |-> (r_state == S_CLEAR) && (r_clr_cnt == '0))
        else $error("table allocated without clearing");

    // a result appears only out of the done state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

    // invalidation only for a completed walk
    a_inv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inv) |-> (r_out_status == ST_DONE))
        else $error("invalidate with a failed status");

    // allocation count stays within the table area
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_next_free != '0)
                                && (r_next_free <= CNT_W'(TABLE_COUNT)))
        else $error("free table pointer out of range");
endmodule

// ===== hdl/four_level_page_table_mapper.sv =====
// four-level page table mapper: a map walk with all levels present reads and evaluates
// each level, writes the leaf and hands over the result; each table allocated adds a
// clear of all 512 entries and a link write; an unmap reads and evaluates each level too,
// then clears the leaf; one item at a time: the next transfer is taken only after the
// result is handed over, later while the output register still holds a result; reset
// clears the root table before the first transfer; table area frame returns to 256, free pointer to 1
module four_level_page_table_mapper import pgtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FRAME_W-1:0] i_cfg_wdata,
    pgtm_in_if.sink            i_in,
    pgtm_out_if.source         o_out
);
    logic [FRAME_W-1:0] r_table_area_frame;
    logic [ENTRY_W-1:0] w_rdata;
    t_fu_req            w_fu_req;
    t_fu_rsp            w_fu_rsp;
    t_store_req         w_store_req;

    // table area register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_area_frame <= TAF_RESET;
        end else if (i_cfg_we) begin
            r_table_area_frame <= i_cfg_wdata;
        end
    end

    pgtm_walk_ctrl u_walk_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_table_area_frame (r_table_area_frame),
        .i_rdata            (w_rdata),
        .i_fu_rsp           (w_fu_rsp),
        .o_fu_req           (w_fu_req),
        .o_store_req        (w_store_req),
        .i_in               (i_in),
        .o_out              (o_out)
    );

    pgtm_frame_unit u_frame_unit (
        .i_req (w_fu_req),
        .o_rsp (w_fu_rsp)
    );

    pgtm_table_store u_table_store (
        .i_clk   (i_clk),
        .i_req   (w_store_req),
        .o_rdata (w_rdata)
    );
endmodule

// ===== bench/tb.sv =====
// self-checking bench for four_level_page_table_mapper: map and unmap commands against a
// behavioural mirror of the table store, with random idling and output back-pressure
// depends on pgtm_pkg, pgtm_in_if, pgtm_out_if and the mapper itself
`timescale 1ns / 1ps

module tb;
    import pgtm_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_MAX    = 48;
    localparam int SHOW_MAX    = 10;

    typedef struct {
        t_status           status;
        logic              invalidate;
        logic [PAGE_W-1:0] invalidate_page;
        logic [USED_W-1:0] tables_used;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FRAME_W-1:0] i_cfg_wdata;

    pgtm_in_if  in_if ();
    pgtm_out_if out_if ();

    four_level_page_table_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // mirror of the table store, free pointer and table area
    logic [ENTRY_W-1:0] mirror_store [STORE_DEPTH];
    int unsigned        free_table;
    logic [FRAME_W-1:0] table_base;

    t_outcome          awaited_outcomes [$];
    logic [PAGE_W-1:0] mapped_pages [$];

    bit          steady;
    bit          hold_asked;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned status_seen [3];
    int unsigned invalidations;
    int unsigned map_count, unmap_count, area_settings;

    always #1 i_clk = ~i_clk;

    function automatic int unsigned page_index(input logic [PAGE_W-1:0] page, input int lvl);
        return int'((page >> (IDX_W * (3 - lvl))) & 36'h1FF);
    endfunction

    function automatic logic [PAGE_W-1:0] random_page();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[PAGE_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] random_frame();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[FRAME_W-1:0];
    endfunction

    // true unless the walk would follow a present link into a table not yet handed out
    function automatic bit walk_stays_allocated(input logic [PAGE_W-1:0] page);
        int unsigned        tbl;
        logic [ENTRY_W-1:0] ent;
        logic [FRAME_W-1:0] rel;
        bit                 ok, open;
        tbl  = 0;
        ok   = 1'b1;
        open = 1'b1;
        for (int lvl = 0; lvl < 3; lvl++) begin
            if (open) begin
                ent = mirror_store[tbl * ENTRIES_PER_TABLE + page_index(page, lvl)];
                rel = ent[ENTRY_W-1:FLAG_W] - table_base;
                if (!ent[0] || rel >= FRAME_W'(TABLE_COUNT)) begin
                    open = 1'b0;
                end else if (rel >= FRAME_W'(free_table)) begin
                    ok   = 1'b0;
                    open = 1'b0;
                end else begin
                    tbl = int'(rel);
                end
            end
        end
        return ok;
    endfunction

    // walk the mirror for one accepted command and queue the outcome it must give
    task automatic apply_page_command(input t_cmd cmd, input logic [PAGE_W-1:0] page,
                                      input logic [FRAME_W-1:0] frame,
                                      input logic [FLAG_W-1:0] flags);
        t_outcome           res;
        int unsigned        tbl, nxt, slot_at;
        logic [ENTRY_W-1:0] ent;
        logic [FRAME_W-1:0] rel;
        bit                 halted;
        res.status          = ST_DONE;
        res.invalidate      = 1'b0;
        res.invalidate_page = '0;
        tbl    = 0;
        nxt    = 0;
        halted = 1'b0;
        for (int lvl = 0; lvl < 3; lvl++) begin
            if (!halted) begin
                slot_at = tbl * ENTRIES_PER_TABLE + page_index(page, lvl);
                ent     = mirror_store[slot_at];
                rel     = ent[ENTRY_W-1:FLAG_W] - table_base;
                if (ent[0] && rel < FRAME_W'(TABLE_COUNT)) begin
                    nxt = int'(rel);
                end else if (ent[0] || cmd == CMD_UNMAP) begin
                    // stray link, or nothing to follow on unmap
                    halted     = 1'b1;
                    res.status = (cmd == CMD_MAP) ? ST_NOSPACE : ST_ABSENT;
                end else if (free_table >= TABLE_COUNT) begin
                    halted     = 1'b1;
                    res.status = ST_NOSPACE;
                end else begin
                    // bump allocation: clear the fresh table and link it in
                    nxt = free_table;
                    for (int k = 0; k < ENTRIES_PER_TABLE; k++)
                        mirror_store[nxt * ENTRIES_PER_TABLE + k] = '0;
                    free_table++;
                    mirror_store[slot_at] = {table_base + FRAME_W'(nxt), flags};
                end
                tbl = nxt;
            end
        end
        if (!halted) begin
            slot_at = tbl * ENTRIES_PER_TABLE + page_index(page, 3);
            if (cmd == CMD_MAP) begin
                mirror_store[slot_at] = {frame, flags};
            end else begin
                mirror_store[slot_at] = '0;
                res.invalidate        = 1'b1;
                res.invalidate_page   = page;
            end
        end
        res.tables_used = USED_W'(free_table);
        awaited_outcomes.push_back(res);
    endtask

    // offer one command, wait for its transfer, then predict it
    task automatic send_item(input t_cmd cmd, input logic [PAGE_W-1:0] page,
                             input logic [FRAME_W-1:0] frame, input logic [FLAG_W-1:0] flags);
        while (!walk_stays_allocated(page))
            page = random_page();
        while (!steady && $urandom_range(99) < 23) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= cmd;
        in_if.virt_page  <= page;
        in_if.phys_frame <= frame;
        in_if.page_flags <= flags;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        apply_page_command(cmd, page, frame, flags);
        if (cmd == CMD_MAP) begin
            map_count++;
            mapped_pages.push_back(page);
            if (mapped_pages.size() > POOL_MAX)
                void'(mapped_pages.pop_front());
        end else begin
            unmap_count++;
        end
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic settle();
        in_if.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_table_area(input logic [FRAME_W-1:0] frame);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= frame;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        table_base   = frame;
        area_settings++;
    endtask

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_outcomes.size() == 0) begin
                note_mismatch("unexpected result, status", '0, 64'(out_if.status));
            end else begin
                want = awaited_outcomes.pop_front();
                if (out_if.status < 3)
                    status_seen[out_if.status]++;
                if (out_if.invalidate === 1'b1)
                    invalidations++;
                if (out_if.status !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(out_if.status));
                if (out_if.invalidate !== want.invalidate)
                    note_mismatch("invalidate", 64'(want.invalidate), 64'(out_if.invalidate));
                if (out_if.invalidate_page !== want.invalidate_page)
                    note_mismatch("invalidate_page", 64'(want.invalidate_page),
                                  64'(out_if.invalidate_page));
                if (out_if.tables_used !== want.tables_used)
                    note_mismatch("tables_used", 64'(want.tables_used),
                                  64'(out_if.tables_used));
            end
        end
    end

    // result side: random idling, a long hold when asked
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_asked) begin
                hold_asked = 1'b0;
                hold_left  = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[four_level_page_table_mapper] ERROR");
            $finish;
        end
    end

    // walks, allocation, leaf clearing and absent-flag links at the reset table area
    task automatic test_directed_walks();
        send_item(CMD_UNMAP, 36'h0, '0, '0);
        send_item(CMD_MAP,   36'h0, '0, 12'hFFF);
        send_item(CMD_MAP,   36'h1, {FRAME_W{1'b1}}, 12'h001);
        send_item(CMD_UNMAP, 36'h1, '0, '0);
        send_item(CMD_UNMAP, 36'h1, '0, '0);
        send_item(CMD_UNMAP, 36'h200, '0, '0);
        send_item(CMD_MAP,   {PAGE_W{1'b1}}, random_frame(), 12'hFFE);
        send_item(CMD_UNMAP, {PAGE_W{1'b1}}, '0, '0);
        send_item(CMD_MAP,   {PAGE_W{1'b1}}, 40'hA5_5A5A_A5A5, 12'h001);
        send_item(CMD_UNMAP, {PAGE_W{1'b1}}, {FRAME_W{1'b1}}, 12'hFFF);
        send_item(CMD_MAP,   36'h8_0000_0000, 40'h55_5555_5555, 12'h555);
        send_item(CMD_MAP,   36'h0_0004_0000, 40'hAA_AAAA_AAAA, 12'hAAB);
        send_item(CMD_UNMAP, 36'h4_0000_0000, '0, '0);
        send_item(CMD_UNMAP, 36'h0_0004_0000, '0, '0);
    endtask

    // moving the table area: stray links, frame wrap, links into the wrong table
    task automatic test_table_area_moves();
        set_table_area({FRAME_W{1'b1}});
        send_item(CMD_MAP,   36'h0, random_frame(), 12'h003);
        send_item(CMD_UNMAP, 36'h0, '0, '0);
        send_item(CMD_MAP,   36'h3_8000_1234, random_frame(), 12'h7F1);
        send_item(CMD_UNMAP, 36'h3_8000_1234, '0, '0);
        set_table_area('0);
        send_item(CMD_MAP,   36'h3_8000_1234, random_frame(), 12'h001);
        send_item(CMD_UNMAP, 36'h3_8000_1235, '0, '0);
        send_item(CMD_MAP,   36'h1_0020_0401, random_frame(), 12'h801);
    endtask

    // result side held off while commands keep coming, so the input stalls
    task automatic test_output_stall();
        settle();
        steady     = 1'b1;
        hold_asked = 1'b1;
        for (int n = 0; n < 8; n++)
            send_item((n % 2) ? CMD_UNMAP : CMD_MAP,
                      mapped_pages[$urandom_range(mapped_pages.size() - 1)],
                      random_frame(), FLAG_W'($urandom) | 12'h001);
        settle();
        steady = 1'b0;
    endtask

    task automatic random_run(input int count);
        logic [PAGE_W-1:0]  page, seed_page;
        logic [FLAG_W-1:0]  flags;
        t_cmd               cmd;
        int unsigned        roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            page = random_page();
            // mostly reuse known paths so that walks go deep
            if (mapped_pages.size() != 0 && roll >= 15) begin
                seed_page = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
                if (roll < 30)
                    page = {seed_page[PAGE_W-1 -: IDX_W], page[PAGE_W-IDX_W-1:0]};
                else if (roll < 40)
                    page = {seed_page[PAGE_W-1 -: 2*IDX_W], page[2*IDX_W-1:0]};
                else if (roll < 75)
                    page = {seed_page[PAGE_W-1:IDX_W], page[IDX_W-1:0]};
                else
                    page = seed_page;
            end
            cmd   = ($urandom_range(99) < 55) ? CMD_MAP : CMD_UNMAP;
            flags = FLAG_W'($urandom);
            if ($urandom_range(99) < 85)
                flags[0] = 1'b1;
            send_item(cmd, page, random_frame(), flags);
        end
    endtask

    // random traffic over several table areas, one stretch without idling
    task automatic test_random_traffic();
        random_run(300);
        set_table_area(random_frame());
        random_run(250);
        set_table_area(TAF_RESET);
        steady = 1'b1;
        random_run(300);
        steady = 1'b0;
        random_run(300);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        in_if.valid      <= 1'b0;
        in_if.command    <= CMD_MAP;
        in_if.virt_page  <= '0;
        in_if.phys_frame <= '0;
        in_if.page_flags <= '0;
        for (int k = 0; k < STORE_DEPTH; k++)
            mirror_store[k] = '0;
        free_table = 1;
        table_base = TAF_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_walks();
        test_table_area_moves();
        test_output_stall();
        test_random_traffic();

        settle();
        repeat (20) @(posedge i_clk);
        fail_count += awaited_outcomes.size();
        $display("covered %0d maps and %0d unmaps over %0d table-area settings",
                 map_count, unmap_count, area_settings + 1);
        $display("results: %0d done, %0d absent, %0d out of space, %0d invalidations, %0d tables",
                 status_seen[ST_DONE], status_seen[ST_ABSENT], status_seen[ST_NOSPACE],
                 invalidations, free_table);
        if (fail_count == 0)
            $display("[four_level_page_table_mapper] OK");
        else
            $display("[four_level_page_table_mapper] ERROR");
        $finish;
    end

endmodule
